// ----- sv/lru_key_value_cache_unit_assert.svh -----
// Assertion macros used by the checker file.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define LKVC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lkvc assertion failed");

// Consequent holds in the cycle after the antecedent.
`define LKVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lkvc assertion failed");

`endif

// ----- sv/lkvc_pkg.sv -----
package lkvc_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 16;

   localparam int DATA_W     = 32;
   localparam int CAP_W      = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // word index of the capacity register
   localparam logic [CSR_ADDR_W-3:0] CSR_CAPACITY_IDX = 1'b0;

   typedef enum logic {
      REQ_LOOKUP = 1'b0,
      REQ_STORE  = 1'b1
   } req_kind_type;

endpackage

// ----- sv/lru_key_value_cache_unit.sv -----
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_type, req_key, req_write_value
// rsp       out        rsp_valid/rsp_stall   rsp_hit, rsp_read_value, rsp_evicted
// csr       in/out     APB psel/penable      capacity register at address 0
//
// One item per cycle while the result is not stalled; an accepted item passes from the input
// register to the result register (tag compare and rank update sit between the two registers).
// Reset clears entry valid bits, recency ranks and fill count; capacity resets to 16.
// A stalled result holds the compute stage; the input register still takes one item.
module lru_key_value_cache_unit #(
   parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic signed [lkvc_pkg::DATA_W-1:0]   req_key,
   input  logic signed [lkvc_pkg::DATA_W-1:0]   req_write_value,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_hit,
   output logic signed [lkvc_pkg::DATA_W-1:0]   rsp_read_value,
   output logic                                 rsp_evicted,

   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lkvc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [lkvc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [lkvc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import lkvc_pkg::*;

   localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W  = CNT_W + CAP_W;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ENTRIES);

   // configuration
   logic [CAP_W-1:0]      capacity_ff;
   logic                  csr_write;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic                  in_type_ff;
   logic [DATA_W-1:0]     in_key_ff;
   logic [DATA_W-1:0]     in_value_ff;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic                  out_hit_ff;
   logic [DATA_W-1:0]     out_read_ff;
   logic                  out_evicted_ff;

   // entry state
   logic [MAX_ENTRIES-1:0] entry_valid_ff, entry_valid_in;
   logic [DATA_W-1:0]      entry_key_ff   [MAX_ENTRIES];
   logic [DATA_W-1:0]      entry_value_ff [MAX_ENTRIES];
   logic [RANK_W-1:0]      rank_ff        [MAX_ENTRIES];
   logic [RANK_W-1:0]      rank_in        [MAX_ENTRIES];
   logic [CNT_W-1:0]       count_ff, count_in;

   // compute stage
   logic                   req_accept;
   logic                   out_free;
   logic                   fire;
   logic                   is_store;
   logic [MAX_ENTRIES-1:0] match;
   logic [MAX_ENTRIES-1:0] victim_oh;
   logic [MAX_ENTRIES-1:0] free_oh;
   logic [MAX_ENTRIES-1:0] target_oh;
   logic [MAX_ENTRIES-1:0] key_we;
   logic [MAX_ENTRIES-1:0] value_we;
   logic                   any_hit;
   logic [RANK_W-1:0]      hit_rank;
   logic [DATA_W-1:0]      hit_value;
   logic [RANK_W-1:0]      last_rank;
   logic [CMP_W-1:0]       cap_ext;
   logic [CMP_W-1:0]       eff_cap;
   logic                   need_evict;
   logic                   insert;
   logic                   evict;
   logic [DATA_W-1:0]      read_value;

   // ---------------- handshake ----------------
   assign out_free    = ~out_valid_ff | ~rsp_stall;
   assign fire        = in_valid_ff & out_free;
   assign req_stall   = in_valid_ff & ~out_free;
   assign req_accept  = req_valid & ~req_stall;
   assign in_valid_in = req_accept | (in_valid_ff & ~out_free);
   assign out_valid_in = fire | (out_valid_ff & rsp_stall);

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite &
                       (csr_paddr[CSR_ADDR_W-1:2] == CSR_CAPACITY_IDX);

   always_comb begin
      if (csr_paddr[CSR_ADDR_W-1:2] == CSR_CAPACITY_IDX) begin
         csr_prdata = {{(CSR_DATA_W-CAP_W){1'b0}}, capacity_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   // ---------------- lookup ----------------
   assign is_store = (in_type_ff == REQ_STORE);

   always_comb begin
      hit_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match[i]     = entry_valid_ff[i] & (entry_key_ff[i] == in_key_ff);
         victim_oh[i] = entry_valid_ff[i] & (rank_ff[i] == last_rank);
         if (match[i]) begin
            hit_rank  = hit_rank | rank_ff[i];
            hit_value = hit_value | entry_value_ff[i];
         end
      end
   end

   assign any_hit   = |match;
   assign last_rank = RANK_W'(count_ff - CNT_W'(1));
   assign free_oh   = ~entry_valid_ff & (entry_valid_ff + MAX_ENTRIES'(1));

   assign cap_ext = CMP_W'(capacity_ff);
   always_comb begin
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > MAX_CMP) begin
         eff_cap = MAX_CMP;
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign need_evict = (CMP_W'(count_ff) >= eff_cap);
   assign insert     = is_store & ~any_hit;
   assign evict      = insert & need_evict;
   assign target_oh  = evict ? victim_oh : free_oh;

   always_comb begin
      if (is_store) begin
         read_value = '0;
      end else if (any_hit) begin
         read_value = hit_value;
      end else begin
         read_value = '1;
      end
   end

   // ---------------- state update ----------------
   always_comb begin
      entry_valid_in = entry_valid_ff;
      key_we         = '0;
      value_we       = '0;
      count_in       = count_ff;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (fire) begin
         if (any_hit) begin
            value_we = is_store ? match : '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (match[i]) begin
                  rank_in[i] = '0;
               end else if (entry_valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
            end
         end else if (insert) begin
            key_we         = target_oh;
            value_we       = target_oh;
            entry_valid_in = entry_valid_ff | target_oh;
            if (!evict) begin
               count_in = count_ff + CNT_W'(1);
            end
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (target_oh[i]) begin
                  rank_in[i] = '0;
               end else if (entry_valid_ff[i]) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
            end
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff    <= CAP_RESET;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
         count_ff       <= '0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            capacity_ff <= csr_pwdata[CAP_W-1:0];
         end
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         entry_valid_ff <= entry_valid_in;
         count_ff       <= count_in;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_type_ff  <= req_type;
         in_key_ff   <= req_key;
         in_value_ff <= req_write_value;
      end
      if (fire) begin
         out_hit_ff     <= any_hit;
         out_read_ff    <= read_value;
         out_evicted_ff <= evict;
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (key_we[i]) begin
            entry_key_ff[i] <= in_key_ff;
         end
         if (value_we[i]) begin
            entry_value_ff[i] <= in_value_ff;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_hit        = out_hit_ff;
   assign rsp_read_value = out_read_ff;
   assign rsp_evicted    = out_evicted_ff;

endmodule

// ----- sv/lkvc_checker.sv -----
`include "lru_key_value_cache_unit_assert.svh"

module lkvc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 req_type,
   input logic signed [lkvc_pkg::DATA_W-1:0]   req_key,
   input logic signed [lkvc_pkg::DATA_W-1:0]   req_write_value,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_hit,
   input logic signed [lkvc_pkg::DATA_W-1:0]   rsp_read_value,
   input logic                                 rsp_evicted,
   input logic                                 csr_psel,
   input logic                                 csr_penable,
   input logic                                 csr_pwrite,
   input logic [lkvc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input logic [lkvc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   input logic [lkvc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   input logic                                 csr_pready
);
   import lkvc_pkg::*;

   // a held result keeps its item
   `LKVC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_hit) && $stable(rsp_read_value) && $stable(rsp_evicted))

   // eviction only on a store of a new key
   `LKVC_ASSERT_SAME(a_evict_no_hit, clock, reset, rsp_valid && rsp_evicted, !rsp_hit && (rsp_read_value == '0))

   // a miss that reads nonzero is a lookup miss
   `LKVC_ASSERT_SAME(a_miss_value, clock, reset, rsp_valid && !rsp_hit && (rsp_read_value != '0), (rsp_read_value == '1) && !rsp_evicted)

   // nothing comes out right after reset
   `LKVC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (.*);
